// File: hdl/pnlr_pkg.sv
// shared constants, codes and types for the pcm normalize resampler
`timescale 1ns / 1ps

package pnlr_pkg;

    localparam int SampleW       = 32;
    localparam int PhaseFracBits = 16;
    localparam int MaxUpsample   = 16;
    localparam int MaxChannels   = 16;
    localparam int StepW         = 21;
    localparam int FmtW          = 2;
    localparam int CountW        = 5;
    localparam int SlotW         = $clog2(MaxChannels);
    localparam int PosW          = StepW + 1;
    localparam int CfgIdxW       = 2;
    localparam int CmdDepth      = 2;
    localparam int CmdPtrW       = $clog2(CmdDepth);
    localparam int CmdCntW       = $clog2(CmdDepth + 1);

    localparam int PhaseOneInt = 1 << PhaseFracBits;
    localparam int MinStepInt  = (PhaseOneInt + MaxUpsample - 1) / MaxUpsample;

    localparam logic [PosW-1:0]   PhaseOne   = PosW'(PhaseOneInt);
    localparam logic [PosW-1:0]   PhaseTwo   = PosW'(2 * PhaseOneInt);
    localparam logic [PosW-1:0]   PosLimit   = PosW'((1 << StepW) + PhaseOneInt);
    localparam logic [StepW-1:0]  MinStep    = StepW'(MinStepInt);
    localparam logic [StepW-1:0]  StepReset  = StepW'(PhaseOneInt);
    localparam logic [CountW-1:0] CountMax   = CountW'(MaxChannels);
    localparam logic [CountW-1:0] CountOne   = CountW'(1);

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CfgPhaseStep    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSampleFormat = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd2;

    // sample format codes
    localparam logic [FmtW-1:0] FmtU8  = 2'd0;
    localparam logic [FmtW-1:0] FmtS16 = 2'd1;
    localparam logic [FmtW-1:0] FmtS32 = 2'd2;

    // command from the front end to the interpolator
    typedef struct packed {
        logic [SampleW-1:0] a;
        logic [SampleW-1:0] b;
        logic               span_en;
        logic               tail_en;
        logic               fin;
    } t_cmd;

endpackage

// File: hdl/pnlr_in_if.sv
// input channel: raw sample beats
`timescale 1ns / 1ps

interface pnlr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_sample;
    logic        is_final;

    modport source (output valid, output raw_sample, output is_final, input ready);
    modport sink   (input valid, input raw_sample, input is_final, output ready);
endinterface

// File: hdl/pnlr_out_if.sv
// output channel: interpolated sample beats
`timescale 1ns / 1ps

interface pnlr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_sample;
    logic               out_last;
    logic               end_only;

    modport source (output valid, output out_sample, output out_last, output end_only,
                    input ready);
    modport sink   (input valid, input out_sample, input out_last, input end_only,
                    output ready);
endinterface

// File: hdl/pnlr_front.sv
// front end: channel select, normalization and command build
`timescale 1ns / 1ps

module pnlr_front import pnlr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pnlr_in_if.sink           i_in,
    input  logic [FmtW-1:0]   i_format,
    input  logic [CountW-1:0] i_chans,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [SlotW-1:0]   r_slot;
    logic [SampleW-1:0] r_prev;
    logic               r_have;

    logic [SampleW-1:0] norm;
    logic               kept;
    logic [CountW-1:0]  slot_inc;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign kept       = (r_slot == '0);
    assign slot_inc   = {{(CountW-SlotW){1'b0}}, r_slot} + CountOne;

    always_comb begin
        case (i_format)
            FmtU8:   norm = {~i_in.raw_sample[7], i_in.raw_sample[6:0], 24'd0};
            FmtS16:  norm = {i_in.raw_sample[15:0], 16'd0};
            default: norm = i_in.raw_sample;
        endcase
    end

    always_comb begin
        o_cmd.a       = r_prev;
        o_cmd.b       = kept ? norm : r_prev;
        o_cmd.span_en = kept && r_have;
        o_cmd.tail_en = kept || r_have;
        o_cmd.fin     = i_in.is_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_prev <= '0;
            r_have <= 1'b0;
        end else if (o_push) begin
            if (i_in.is_final) begin
                r_slot <= '0;
                r_prev <= '0;
                r_have <= 1'b0;
            end else begin
                if (kept) begin
                    r_prev <= norm;
                    r_have <= 1'b1;
                end
                // a slot at or past the count wraps to channel 0
                r_slot <= (slot_inc >= i_chans) ? '0 : slot_inc[SlotW-1:0];
            end
        end
    end

endmodule

// File: hdl/pnlr_cmd_fifo.sv
// short command queue between front end and interpolator
`timescale 1ns / 1ps

module pnlr_cmd_fifo import pnlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    input  logic i_pop,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    t_cmd                r_mem [CmdDepth];
    logic [CmdPtrW-1:0]  r_wr_ptr;
    logic [CmdPtrW-1:0]  r_rd_ptr;
    logic [CmdCntW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CmdCntW'(CmdDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CmdPtrW'(CmdDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CmdPtrW'(CmdDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/pnlr_back.sv
// interpolator: phase accumulator, one output point per cycle while in a span and the output register is free
`timescale 1ns / 1ps

module pnlr_back import pnlr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [StepW-1:0] i_step,
    input  t_cmd             i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    pnlr_out_if.source       o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPAN1,
        S_SPAN2,
        S_MARK
    } t_state;

    t_state               r_state;
    logic [PosW-1:0]      r_pos;
    logic [SampleW-1:0]   r_a;
    logic [SampleW-1:0]   r_b;
    logic signed [SampleW:0] r_diff;
    logic                 r_fin;
    logic                 r_tail_en;
    logic                 r_any;
    logic                 r_out_valid;
    logic [SampleW-1:0]   r_out_sample;
    logic                 r_out_last;
    logic                 r_end_only;

    logic                 out_free;
    logic                 in_span;
    logic                 emit;
    logic [PosW-1:0]      npos;
    logic signed [SampleW+PhaseFracBits+1:0] prod;
    logic signed [SampleW+1:0] quo;
    logic signed [SampleW+1:0] sum;
    logic                 last_span1;
    logic                 last_span2;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_span  = (r_pos < PhaseOne);
    assign npos     = r_pos + {{(PosW-StepW){1'b0}}, i_step};
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // a beat is loaded into the output register this cycle
    assign emit = out_free && ((((r_state == S_SPAN1) || (r_state == S_SPAN2)) && in_span)
                               || (r_state == S_MARK));

    // floor of diff * frac / 2^frac_bits is an arithmetic shift
    assign prod = r_diff * $signed({1'b0, r_pos[PhaseFracBits-1:0]});
    assign quo  = prod[SampleW+PhaseFracBits+1:PhaseFracBits];
    assign sum  = $signed({{2{r_a[SampleW-1]}}, r_a}) + quo;

    // last point of the stream when no tail point follows
    assign last_span1 = r_fin && (npos >= PhaseOne) && (!r_tail_en || (npos >= PhaseTwo));
    assign last_span2 = (npos >= PhaseOne);

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.out_last   = r_out_last;
    assign o_out.end_only   = r_end_only;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fin       <= 1'b0;
            r_tail_en   <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_b       <= i_cmd.b;
                        r_fin     <= i_cmd.fin;
                        r_tail_en <= i_cmd.tail_en;
                        r_any     <= 1'b0;
                        if (i_cmd.span_en) begin
                            r_a     <= i_cmd.a;
                            r_diff  <= $signed({i_cmd.b[SampleW-1], i_cmd.b})
                                     - $signed({i_cmd.a[SampleW-1], i_cmd.a});
                            r_state <= S_SPAN1;
                        end else begin
                            r_a    <= i_cmd.b;
                            r_diff <= '0;
                            if (i_cmd.fin && i_cmd.tail_en) begin
                                r_state <= S_SPAN2;
                            end else if (i_cmd.fin) begin
                                r_state <= S_MARK;
                            end
                        end
                    end
                end
                S_SPAN1: begin
                    if (in_span) begin
                        if (out_free) begin
                            r_out_sample <= sum[SampleW-1:0];
                            r_out_last   <= last_span1;
                            r_end_only   <= 1'b0;
                            r_pos        <= npos;
                            r_any        <= 1'b1;
                        end
                    end else begin
                        if (r_fin && r_tail_en) begin
                            // tail holds the last sample at both ends
                            r_pos   <= r_pos - PhaseOne;
                            r_a     <= r_b;
                            r_diff  <= '0;
                            r_state <= S_SPAN2;
                        end else if (r_fin) begin
                            r_pos   <= '0;
                            r_state <= r_any ? S_IDLE : S_MARK;
                        end else begin
                            r_pos   <= r_pos - PhaseOne;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SPAN2: begin
                    if (in_span) begin
                        if (out_free) begin
                            r_out_sample <= sum[SampleW-1:0];
                            r_out_last   <= last_span2;
                            r_end_only   <= 1'b0;
                            r_pos        <= npos;
                            r_any        <= 1'b1;
                        end
                    end else begin
                        r_pos   <= '0;
                        r_state <= r_any ? S_IDLE : S_MARK;
                    end
                end
                S_MARK: begin
                    if (out_free) begin
                        r_out_sample <= '0;
                        r_out_last   <= 1'b1;
                        r_end_only   <= 1'b1;
                        r_pos        <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_end_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_end_only) |-> (r_out_last && (r_out_sample == '0)))
        else $error("end marker beat without last flag or with nonzero sample");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos < PosLimit))
        else $error("phase accumulator out of range");

    a_mark_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MARK) && out_free) |=> ((r_pos == '0) && (r_state == S_IDLE)))
        else $error("stream end did not clear the phase");
`endif

endmodule

// File: hdl/pcm_normalize_linear_resampler_core.sv
// top level: configuration registers, front end, command queue, interpolator
// an accepted beat passes the command queue and interpolator span state before the output register
// throughput: one output point per cycle while the output is not stalled, but closing
//   a span or taking a command in idle yields no point; a stream end adds a tail span
// a two-entry command queue lets the front end take beats while points are produced
// reset is synchronous: stream state clears and configuration registers return to their reset values
`timescale 1ns / 1ps

module pcm_normalize_linear_resampler_core import pnlr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pnlr_in_if.sink            i_in,
    pnlr_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [StepW-1:0]   i_cfg_wdata
);

    logic [StepW-1:0]  r_step;
    logic [FmtW-1:0]   r_format;
    logic [CountW-1:0] r_chans;

    logic [CountW-1:0] wr_count;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd wr_cmd;
    t_cmd rd_cmd;

    assign wr_count = i_cfg_wdata[CountW-1:0];

    // step and channel count are stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= StepReset;
            r_format <= FmtS16;
            r_chans  <= CountOne;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgPhaseStep: begin
                    r_step <= (i_cfg_wdata < MinStep) ? MinStep : i_cfg_wdata;
                end
                CfgSampleFormat: begin
                    r_format <= i_cfg_wdata[FmtW-1:0];
                end
                CfgChannelCount: begin
                    if (wr_count == '0) begin
                        r_chans <= CountOne;
                    end else if (wr_count > CountMax) begin
                        r_chans <= CountMax;
                    end else begin
                        r_chans <= wr_count;
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    pnlr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_format (r_format),
        .i_chans  (r_chans),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (wr_cmd)
    );

    pnlr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_cmd),
        .i_pop   (pop),
        .o_rdata (rd_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    pnlr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_step),
        .i_cmd   (rd_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
